/* hdl/xffe_pkg.sv */
// Shared types and constants of the forwarded-for IPv4 extractor.
package xffe_pkg;

	localparam int unsigned NAME_LEN = 16;

	// Header name in lower case, including the colon.
	localparam logic [7:0] NAME_TEXT [NAME_LEN] = '{
		8'h78, 8'h2D, 8'h66, 8'h6F, 8'h72, 8'h77, 8'h61, 8'h72,
		8'h64, 8'h65, 8'h64, 8'h2D, 8'h66, 8'h6F, 8'h72, 8'h3A
	};

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_SHIFT = 8'h20;

	localparam logic [11:0] OCTET_MAX = 12'd255;
	localparam logic [1:0]  LAST_OCTET = 2'd3;
	localparam logic [1:0]  MAX_DIGITS = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_ABSENT = 2'd0;
	localparam status_t ST_BAD    = 2'd1;
	localparam status_t ST_VALID  = 2'd2;

	typedef enum logic [1:0] {
		PH_LEAD   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_TRAIL  = 2'd2,
		PH_BAD    = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  octet_idx;
		logic [1:0]  digit_cnt;
		logic [7:0]  octet_val;
		logic [23:0] addr_acc;
	} tok_state_t;

	// Control from the header tracker to the token parser.
	typedef struct packed {
		logic step;     // a byte is processed this cycle
		logic feed;     // byte belongs to the header value
		logic clear;    // header name just completed
		logic restart;  // final byte of the request
	} tok_ctl_t;

	// Verdict on the token as it stands after the current byte.
	typedef struct packed {
		logic        valid;
		logic [31:0] address;
	} tok_verdict_t;

endpackage

/* hdl/xffe_byte_if.sv */
// Request byte channel: valid/ready handshake carrying one byte per beat.
interface xffe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_request;

	modport source (output valid, output data_byte, output end_of_request, input ready);
	modport sink (input valid, input data_byte, input end_of_request, output ready);
endinterface

/* hdl/xffe_result_if.sv */
// Result channel: valid/ready handshake carrying status and client address.
interface xffe_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] client_address;

	modport source (output valid, output status, output client_address, input ready);
	modport sink (input valid, input status, input client_address, output ready);
endinterface

/* hdl/forwarded_for_ipv4_extractor_unit.sv */
// Top level of the rightmost X-Forwarded-For IPv4 extractor.
//
// The request channel takes the text of an HTTP request, one byte per beat, with
// end_of_request marking the final byte. The result channel gives exactly one
// beat per request, after its final byte: status 0 when no x-forwarded-for
// header was found at a line start, 1 when the rightmost token of the last such
// header is empty or not a strict dotted quad, and 2 with the address in
// client_address (first octet in bits 31..24) otherwise.
// Throughput is one byte per clock. A byte is registered at the input, the
// header tracker and token parser update their state from it, and on a final
// byte the verdict is loaded into the result register. When the receiver
// stalls, a waiting result holds; bytes that are not final keep flowing, and
// only a second final byte waits in the input register until the result slot
// frees. After each final byte all parsing state returns to its reset value,
// so the next byte starts a new request. Reset empties the input and result
// registers and clears all parsing state; nothing is lost or repeated.
module forwarded_for_ipv4_extractor_unit
	import xffe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	xffe_byte_if.sink            request,
	xffe_result_if.source        result
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Header tracking state.
	logic        line_start_q;
	logic [3:0]  name_cnt_q;
	logic        in_value_q;
	logic        prev_cr_q;
	logic        header_seen_q;
	logic        commit_valid_q;
	logic [31:0] commit_addr_q;

	logic        line_start_n;
	logic [3:0]  name_cnt_n;
	logic        in_value_n;
	logic        prev_cr_n;
	logic        header_seen_n;
	logic        commit_valid_n;
	logic [31:0] commit_addr_n;

	// Result register.
	logic        out_valid_q;
	status_t     out_status_q;
	logic [31:0] out_addr_q;

	logic         step;
	logic         eol;
	logic [7:0]   lower;
	tok_ctl_t     tok_ctl;
	tok_verdict_t tok_verdict;
	logic         final_valid;
	logic [31:0]  final_addr;
	status_t      final_status;

	// A byte moves on unless it is final and the result slot is still occupied.
	assign step = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign request.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			byte_s1 <= request.data_byte;
			last_s1 <= request.end_of_request;
		end
	end

	assign eol   = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);
	assign lower = (byte_s1 >= CH_UPPER_A && byte_s1 <= CH_UPPER_Z) ?
		byte_s1 + CASE_SHIFT : byte_s1;

	// Token parser control, decoded from the registered tracking state and the registered byte.
	always_comb begin
		tok_ctl.step    = step;
		tok_ctl.restart = last_s1;
		tok_ctl.feed    = in_value_q && !(byte_s1 == CH_LF && prev_cr_q);
		tok_ctl.clear   = !in_value_q && line_start_q && (lower == NAME_TEXT[name_cnt_q]) &&
			(name_cnt_q == 4'(NAME_LEN - 1));
	end

	// Header name matching and value boundaries. A value ends only at CR LF;
	// a lone LF is fed to the token parser like any other value byte.
	always_comb begin
		line_start_n   = line_start_q;
		name_cnt_n     = name_cnt_q;
		in_value_n     = in_value_q;
		prev_cr_n      = prev_cr_q;
		header_seen_n  = header_seen_q;
		commit_valid_n = commit_valid_q;
		commit_addr_n  = commit_addr_q;
		if (in_value_q) begin
			if (byte_s1 == CH_LF && prev_cr_q) begin
				// No feed this cycle, so the verdict reflects the closed token.
				commit_valid_n = tok_verdict.valid;
				commit_addr_n  = tok_verdict.address;
				in_value_n     = 1'b0;
				prev_cr_n      = 1'b0;
				line_start_n   = 1'b1;
				name_cnt_n     = 4'd0;
			end else begin
				prev_cr_n    = (byte_s1 == CH_CR);
			end
		end else if (line_start_q) begin
			if (lower == NAME_TEXT[name_cnt_q]) begin
				if (name_cnt_q == 4'(NAME_LEN - 1)) begin
					name_cnt_n    = 4'd0;
					line_start_n  = 1'b0;
					in_value_n    = 1'b1;
					header_seen_n = 1'b1;
					prev_cr_n     = 1'b0;
				end else begin
					name_cnt_n = name_cnt_q + 4'd1;
				end
			end else begin
				name_cnt_n   = 4'd0;
				line_start_n = eol;
			end
		end else begin
			line_start_n = eol;
		end
	end

	xffe_token u_token (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tok_ctl),
		.data_byte (byte_s1),
		.verdict   (tok_verdict)
	);

	// An open value is judged as it stands; otherwise the last closed one counts.
	assign final_valid = in_value_n ? tok_verdict.valid : commit_valid_n;
	assign final_addr  = in_value_n ? tok_verdict.address : commit_addr_n;
	assign final_status = !header_seen_n ? ST_ABSENT :
		(final_valid ? ST_VALID : ST_BAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q   <= 1'b1;
			name_cnt_q     <= 4'd0;
			in_value_q     <= 1'b0;
			prev_cr_q      <= 1'b0;
			header_seen_q  <= 1'b0;
			commit_valid_q <= 1'b0;
			commit_addr_q  <= 32'd0;
		end else if (step) begin
			if (last_s1) begin
				line_start_q   <= 1'b1;
				name_cnt_q     <= 4'd0;
				in_value_q     <= 1'b0;
				prev_cr_q      <= 1'b0;
				header_seen_q  <= 1'b0;
				commit_valid_q <= 1'b0;
				commit_addr_q  <= 32'd0;
			end else begin
				line_start_q   <= line_start_n;
				name_cnt_q     <= name_cnt_n;
				in_value_q     <= in_value_n;
				prev_cr_q      <= prev_cr_n;
				header_seen_q  <= header_seen_n;
				commit_valid_q <= commit_valid_n;
				commit_addr_q  <= commit_addr_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_status_q <= final_status;
			out_addr_q   <= (final_status == ST_VALID) ? final_addr : 32'd0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_status_q;
	assign result.client_address = out_addr_q;

	// A header value and a pending name match exclude each other.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_value_q && line_start_q))
		else $error("value tracking and line start both active");

	assert property (@(posedge clk) disable iff (!arst_n)
		name_cnt_q != 4'd0 |-> line_start_q)
		else $error("name match in progress away from a line start");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_status_q == ST_ABSENT || out_status_q == ST_BAD ||
			out_status_q == ST_VALID))
		else $error("result carries an undefined status");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_addr_q != 32'd0 |-> out_status_q == ST_VALID)
		else $error("address reported without a valid status");

	assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> !header_seen_q && !in_value_q && line_start_q)
		else $error("parsing state not restarted after a final byte");

endmodule

/* hdl/xffe_token.sv */
// Dotted-quad parser for the rightmost comma-separated token of a header value.
module xffe_token
	import xffe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  tok_ctl_t     ctl,
	input  logic [7:0]   data_byte,
	output tok_verdict_t verdict
);

	tok_state_t cur_q;
	tok_state_t fed;
	tok_state_t nxt;
	tok_state_t empty;

	logic        is_space;
	logic        is_digit;
	logic [11:0] value;

	assign empty = '{phase: PH_LEAD, octet_idx: 2'd0, digit_cnt: 2'd0,
		octet_val: 8'd0, addr_acc: 24'd0};

	assign is_space = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
		(data_byte == CH_CR) || (data_byte == CH_LF);
	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	// octet * 10 + digit, as two shifts and adds
	assign value = {1'b0, cur_q.octet_val, 3'b000} + {3'b000, cur_q.octet_val, 1'b0}
		+ {4'd0, data_byte - CH_ZERO};

	always_comb begin
		fed = cur_q;
		if (data_byte == CH_COMMA) begin
			fed = empty;
		end else if (cur_q.phase == PH_BAD) begin
			fed = cur_q;
		end else if (is_space) begin
			if (cur_q.phase == PH_DIGITS) begin
				fed.phase = PH_TRAIL;
			end
		end else if (cur_q.phase == PH_TRAIL) begin
			fed.phase = PH_BAD;
		end else if (is_digit) begin
			if (cur_q.digit_cnt == MAX_DIGITS || value > OCTET_MAX) begin
				fed.phase = PH_BAD;
			end else begin
				fed.phase     = PH_DIGITS;
				fed.octet_val = value[7:0];
				fed.digit_cnt = cur_q.digit_cnt + 2'd1;
			end
		end else if (data_byte == CH_DOT && cur_q.phase == PH_DIGITS &&
				cur_q.digit_cnt != 2'd0 && cur_q.octet_idx != LAST_OCTET) begin
			fed.addr_acc  = {cur_q.addr_acc[15:0], cur_q.octet_val};
			fed.octet_idx = cur_q.octet_idx + 2'd1;
			fed.digit_cnt = 2'd0;
			fed.octet_val = 8'd0;
		end else begin
			fed.phase = PH_BAD;
		end
	end

	always_comb begin
		if (ctl.clear) begin
			nxt = empty;
		end else if (ctl.feed) begin
			nxt = fed;
		end else begin
			nxt = cur_q;
		end
	end

	assign verdict.valid = (nxt.phase == PH_DIGITS || nxt.phase == PH_TRAIL) &&
		nxt.octet_idx == LAST_OCTET && nxt.digit_cnt != 2'd0;
	assign verdict.address = {nxt.addr_acc, nxt.octet_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= empty;
		end else if (ctl.step) begin
			cur_q <= ctl.restart ? empty : nxt;
		end
	end

endmodule

/* dv/forwarded_for_ipv4_extractor_unit_tb.sv */
// Self-checking testbench for the forwarded-for IPv4 extractor top level.
`timescale 1ns / 1ps

module forwarded_for_ipv4_extractor_unit_tb
	import xffe_pkg::*;
;

	// Clock, reset and run limits. The slowest correct run spends per byte the
	// drawn sender gap, the beat itself, and a little for a final byte that waits
	// behind a stalled result, so the limit below leaves a wide margin over the
	// thousand or so bytes that are sent.
	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 5;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 12;
	localparam int RANDOM_BYTES  = 350;
	localparam int RANDOM_MIN_RQ = 4;
	localparam int DIR_ROWS      = 22;

	// What a request should report. The typed flag marks directed rows whose
	// verdict is written down by hand instead of taken from the predictor.
	typedef struct packed {
		logic        typed;
		status_t     st;
		logic [31:0] addr;
	} row_want_t;

	typedef struct packed {
		status_t     st;
		logic [31:0] addr;
	} verdict_t;

	localparam row_want_t PREDICT = '{1'b0, ST_ABSENT, 32'h0};

	logic clk = 1'b0;
	logic arst_n;

	xffe_byte_if   req_if ();
	xffe_result_if res_if ();

	forwarded_for_ipv4_extractor_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_if),
		.result (res_if)
	);

	always #CLK_HALF clk = ~clk;

	// Scoreboard: one planned verdict per request is queued by the sender, and
	// turned into an expected result when the final byte of that request is
	// accepted. Results are compared in order against the expected verdicts.
	row_want_t   request_plan_q [$];
	verdict_t    verdict_q [$];
	logic [7:0]  req_bytes [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          rx_stall = 0;
	logic        rx_quiet = 1'b0;

	// Predictor state: header-name tracking, the token being parsed, and the
	// verdict of the last header value that was closed by CR LF.
	logic        line_start;
	logic [4:0]  name_pos;
	logic        in_value;
	logic        prev_cr;
	phase_t      tok_phase;
	logic [1:0]  tok_idx;
	logic [1:0]  tok_digits;
	logic [7:0]  tok_oct;
	logic [23:0] tok_acc;
	logic        hdr_seen;
	logic        closed_ok;
	logic [31:0] closed_addr;

	task automatic report_mismatch(input string msg);
		$display("[%0d] mismatch: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic tok_restart();
		tok_phase  = PH_LEAD;
		tok_idx    = '0;
		tok_digits = '0;
		tok_oct    = '0;
		tok_acc    = '0;
	endtask

	task automatic xff_clear();
		line_start  = 1'b1;
		name_pos    = '0;
		in_value    = 1'b0;
		prev_cr     = 1'b0;
		hdr_seen    = 1'b0;
		closed_ok   = 1'b0;
		closed_addr = '0;
		tok_restart();
	endtask

	function automatic logic tok_is_quad();
		return (tok_phase == PH_DIGITS || tok_phase == PH_TRAIL) &&
			tok_idx == LAST_OCTET && tok_digits != 0;
	endfunction

	// Advance the token parser by one value byte. A comma always starts a new
	// token, so only the rightmost token survives to the end of the value.
	task automatic tok_take(input logic [7:0] b);
		int v;
		if (b == CH_COMMA) begin
			tok_restart();
			return;
		end
		if (tok_phase == PH_BAD)
			return;
		if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
			if (tok_phase == PH_DIGITS)
				tok_phase = PH_TRAIL;
			return;
		end
		// Anything but whitespace after trailing whitespace spoils the token.
		if (tok_phase == PH_TRAIL) begin
			tok_phase = PH_BAD;
			return;
		end
		if (b >= CH_ZERO && b <= CH_NINE) begin
			v = int'(tok_oct) * 10 + int'(b - CH_ZERO);
			tok_phase = PH_DIGITS;
			if (tok_digits >= MAX_DIGITS || v > int'(OCTET_MAX)) begin
				tok_phase = PH_BAD;
				return;
			end
			tok_oct = v[7:0];
			tok_digits++;
			return;
		end
		if (b == CH_DOT && tok_phase == PH_DIGITS && tok_digits != 0 &&
				tok_idx < LAST_OCTET) begin
			tok_acc    = {tok_acc[15:0], tok_oct};
			tok_idx++;
			tok_digits = '0;
			tok_oct    = '0;
			return;
		end
		tok_phase = PH_BAD;
	endtask

	// Take one accepted beat into the predictor. On a final byte it yields the
	// verdict of the whole request and returns to the reset state.
	task automatic xff_track_byte(input logic [7:0] b, input logic last,
			output logic got, output verdict_t want);
		logic [7:0]  folded;
		logic        eol;
		logic        ok;
		logic [31:0] a;
		got  = 1'b0;
		want = '{ST_ABSENT, 32'h0};
		eol  = (b == CH_CR) || (b == CH_LF);
		if (in_value) begin
			// Only CR LF closes a value; a lone LF is just whitespace in it.
			if (b == CH_LF && prev_cr) begin
				closed_ok   = tok_is_quad();
				closed_addr = {tok_acc, tok_oct};
				in_value    = 1'b0;
				prev_cr     = 1'b0;
				line_start  = 1'b1;
				name_pos    = '0;
			end else begin
				tok_take(b);
				prev_cr = (b == CH_CR);
			end
		end else if (line_start) begin
			// Case folding applies to A through Z only.
			folded = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_SHIFT : b;
			if (folded == NAME_TEXT[name_pos[3:0]]) begin
				name_pos++;
				if (name_pos == 5'(NAME_LEN)) begin
					name_pos   = '0;
					line_start = 1'b0;
					in_value   = 1'b1;
					hdr_seen   = 1'b1;
					prev_cr    = 1'b0;
					tok_restart();
				end
			end else begin
				name_pos   = '0;
				line_start = eol;
			end
		end else begin
			line_start = eol;
		end
		if (!last)
			return;
		// A value still open at the final byte is judged as it stands.
		ok = in_value ? tok_is_quad() : closed_ok;
		a  = in_value ? {tok_acc, tok_oct} : closed_addr;
		got = 1'b1;
		if (!hdr_seen)
			want = '{ST_ABSENT, 32'h0};
		else if (ok)
			want = '{ST_VALID, a};
		else
			want = '{ST_BAD, 32'h0};
		xff_clear();
	endtask

	// Input monitor and result checker, both sampled at the rising edge.
	always @(posedge clk) begin
		logic      got;
		verdict_t  want;
		verdict_t  pred;
		row_want_t plan;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				xff_track_byte(req_if.data_byte, req_if.end_of_request, got, pred);
				if (got) begin
					if (request_plan_q.size() == 0) begin
						report_mismatch("final byte accepted with no request planned");
					end else begin
						plan = request_plan_q.pop_front();
						want = plan.typed ? verdict_t'{plan.st, plan.addr} : pred;
						verdict_q.push_back(want);
					end
				end
			end
			if (res_if.valid && res_if.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing expected: status %0d addr %h",
						res_if.status, res_if.client_address));
				end else begin
					want = verdict_q.pop_front();
					if (res_if.status !== want.st)
						report_mismatch($sformatf("status %0d, expected %0d",
							res_if.status, want.st));
					if (res_if.client_address !== want.addr)
						report_mismatch($sformatf("client_address %h, expected %h",
							res_if.client_address, want.addr));
				end
				// Draw the receiver's stall before the next result beat, and now and
				// then switch between stalling and a stretch of steady readiness.
				rx_stall = rx_quiet ? 0 : $urandom_range(0, 15);
				if ($urandom_range(0, 7) == 0)
					rx_quiet = !rx_quiet;
			end
		end
	end

	// Receiver side: ready drops for the drawn number of cycles after each beat.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (rx_stall != 0) begin
			res_if.ready <= 1'b0;
			rx_stall--;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// Watchdog over the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			req_bytes.push_back(s[i]);
	endfunction

	// Octet text with up to three digits, sometimes with leading zeros.
	function automatic string octet_text(input int v);
		string s;
		s = $sformatf("%0d", v);
		repeat ($urandom_range(0, 3 - s.len()))
			s = {"0", s};
		return s;
	endfunction

	function automatic int pick_octet();
		int k;
		k = $urandom_range(0, 7);
		if (k == 0)
			return 0;
		if (k == 1)
			return 255;
		return $urandom_range(0, 255);
	endfunction

	function automatic void push_pad();
		int k;
		repeat ($urandom_range(0, 2)) begin
			k = $urandom_range(0, 9);
			push_text(k < 6 ? " " : (k < 9 ? "\t" : "\r"));
		end
	endfunction

	// One comma-separated token: mostly a proper dotted quad, otherwise one of
	// the ways a token goes wrong.
	function automatic void push_token();
		string tok;
		int    k;
		int    n;
		int    pos;
		k   = $urandom_range(0, 15);
		n   = (k == 12) ? 3 : ((k == 13) ? 5 : 4);
		tok = "";
		if (k == 9) begin
			return;
		end
		if (k == 15) begin
			repeat ($urandom_range(1, 4))
				req_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		for (int i = 0; i < n; i++) begin
			if (i != 0)
				tok = {tok, "."};
			if (k == 10 && i == n - 1)
				tok = {tok, $sformatf("%0d", $urandom_range(256, 999))};
			else if (k == 11 && i == 0)
				tok = {tok, $sformatf("%04d", $urandom_range(0, 255))};
			else
				tok = {tok, octet_text(pick_octet())};
		end
		if (k == 14) begin
			pos = $urandom_range(1, tok.len() - 1);
			case ($urandom_range(0, 4))
				0: tok = {tok.substr(0, pos - 1), "a", tok.substr(pos, tok.len() - 1)};
				1: tok = {tok.substr(0, pos - 1), " ", tok.substr(pos, tok.len() - 1)};
				2: tok = {tok.substr(0, pos - 1), "\n", tok.substr(pos, tok.len() - 1)};
				3: tok = {tok.substr(0, pos - 1), ".", tok.substr(pos, tok.len() - 1)};
				default: tok = {tok.substr(0, pos - 1), "/", tok.substr(pos, tok.len() - 1)};
			endcase
		end
		push_text(tok);
	endfunction

	// Header name in a random mix of cases, now and then with one byte spoiled.
	function automatic void push_name();
		logic [7:0] c;
		int         spoil;
		spoil = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NAME_LEN - 1) : -1;
		for (int i = 0; i < NAME_LEN; i++) begin
			c = NAME_TEXT[i];
			if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
				c = c - CASE_SHIFT;
			if (i == spoil)
				c = 8'($urandom_range(0, 255));
			req_bytes.push_back(c);
		end
	endfunction

	function automatic void push_filler();
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 6))
				req_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			push_text("Host: h");
		end
		if ($urandom_range(0, 5) == 0)
			push_text("\n");
		else
			push_text("\r\n");
	endfunction

	// A random request: mostly well-formed header lines with random addresses,
	// and some noise or broken structure.
	function automatic void build_random_request();
		int nhdr;
		int ntok;
		req_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				req_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 2) == 0)
			push_filler();
		nhdr = ($urandom_range(0, 3) == 0) ? 2 : 1;
		for (int h = 0; h < nhdr; h++) begin
			// Sometimes the name lands in the middle of a line, where it is no header.
			if ($urandom_range(0, 11) == 0)
				push_text("a: ");
			push_name();
			ntok = $urandom_range(1, 3);
			for (int t = 0; t < ntok; t++) begin
				push_pad();
				push_token();
				push_pad();
				if (t != ntok - 1)
					push_text(",");
			end
			if (h != nhdr - 1 || $urandom_range(0, 1) == 1)
				push_text("\r\n");
		end
		if ($urandom_range(0, 3) == 0)
			push_filler();
	endfunction

	// Send the bytes in req_bytes as one request, with a drawn gap before each
	// beat. Some requests go out without any gaps at all.
	task automatic send_request(input row_want_t plan);
		int   gap;
		logic steady;
		steady = ($urandom_range(0, 3) == 0);
		request_plan_q.push_back(plan);
		for (int i = 0; i < req_bytes.size(); i++) begin
			gap = steady ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (gap != 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			req_if.valid          <= 1'b1;
			req_if.data_byte      <= req_bytes[i];
			req_if.end_of_request <= (i == req_bytes.size() - 1);
			do @(posedge clk); while (!req_if.ready);
		end
	endtask

	// Hold the sender off until every result that is owed has come back.
	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (request_plan_q.size() != 0 || verdict_q.size() != 0)
			@(negedge clk);
	endtask

	// Directed requests: plain headers, the octet extremes, letter case, values
	// closed by CR LF or by the end of the request, empty and spoiled tokens, a
	// lone LF or CR inside a value, the name outside a line start or inside a
	// value, and repeated headers where the last one wins.
	string dir_text [DIR_ROWS] = '{
		"GET / HTTP/1.1\r\nHost: a\r\n\r\n",
		"X-Forwarded-For: 10.0.0.1\r\n\r\n",
		"x-forwarded-for: 1.2.3.4, 255.255.255.255",
		"x-forwarded-for: 0.0.0.0",
		"x-FORWARDED-for:1.2.3.256",
		"x-forwarded-for: 001.02.3.4 \t",
		"x-forwarded-for: 1.2.3.4,",
		"x-forwarded-for:",
		"x-forwarded-for: 1.2.3.4\n5",
		"a: b x-forwarded-for: 1.2.3.4\r\n",
		"x-forwarded-for: 1.2.3\r\nx-forwarded-for: 9.8.7.6\r\n",
		"x-forwarded-for: 9.8.7.6\r\nX-FORWARDED-FOR: junk\r\n",
		"x-forwarded-for: 1.2.3.4 x-forwarded-for: 5.6.7.8",
		"x-forwarded-for: 1.2.3.4.5",
		"x-forwarded-for: 1234.1.1.1",
		"x-forwarded-for: 1 .2.3.4",
		"x-forwarded-fo\r\nx-forwarded-for: 4.3.2.1",
		"x\rforwarded-for: 1.1.1.1",
		"X-Forwarded-For: 1.2.3.4\r5",
		"x-forwarded-for: 1..2.3",
		"x-forwarded-for: 10.20.30.40 , 192.168.1.1\r\nHost: z",
		"Via: x\nx-Forwarded-for:\t7.7.7.7\t\r\n"
	};

	row_want_t dir_want [DIR_ROWS] = '{
		'{1'b1, ST_ABSENT, 32'h0},
		'{1'b1, ST_VALID,  32'h0A000001},
		'{1'b1, ST_VALID,  32'hFFFFFFFF},
		'{1'b1, ST_VALID,  32'h00000000},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_VALID,  32'h01020304},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_ABSENT, 32'h0},
		'{1'b1, ST_VALID,  32'h09080706},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_VALID,  32'h04030201},
		'{1'b1, ST_ABSENT, 32'h0},
		'{1'b1, ST_BAD,    32'h0},
		'{1'b1, ST_BAD,    32'h0},
		PREDICT,
		PREDICT
	};

	initial begin
		int rand_bytes;
		int rand_requests;
		arst_n                = 1'b0;
		req_if.valid          = 1'b0;
		req_if.data_byte      = 8'h00;
		req_if.end_of_request = 1'b0;
		res_if.ready          = 1'b0;
		xff_clear();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			req_bytes.delete();
			push_text(dir_text[r]);
			send_request(dir_want[r]);
		end
		// The byte extremes as one-byte requests: neither can start a header.
		req_bytes.delete();
		req_bytes.push_back(8'h00);
		send_request('{1'b1, ST_ABSENT, 32'h0});
		req_bytes.delete();
		req_bytes.push_back(8'hFF);
		send_request('{1'b1, ST_ABSENT, 32'h0});

		// Let the pipeline empty completely once before the random part.
		wait_drained();

		rand_bytes    = 0;
		rand_requests = 0;
		while (rand_bytes < RANDOM_BYTES || rand_requests < RANDOM_MIN_RQ) begin
			build_random_request();
			rand_bytes += req_bytes.size();
			rand_requests++;
			send_request(PREDICT);
			if ($urandom_range(0, 15) == 0)
				wait_drained();
		end

		// Everything is sent; wait for the last results, then watch a little
		// longer for any stray beat.
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
